// ----- hw/rtl/ssee_pkg.sv -----
// Shared types, constants and helpers for the sum-of-products evaluator.
// Used by ssee_step, ssee_out and the top level; depends on nothing.
package ssee_pkg;

   localparam int VALUE_WIDTH  = 32;
   localparam int RSP_DATA_W   = ((VALUE_WIDTH + 7) / 8) * 8;
   localparam int CH_WIDTH     = 8;
   localparam int STATUS_WIDTH = 2;
   localparam int DIGIT_WIDTH  = 4;

   localparam logic [VALUE_WIDTH-1:0] VALUE_ZERO = '0;
   localparam logic [VALUE_WIDTH-1:0] VALUE_ONE  = {{(VALUE_WIDTH-1){1'b0}}, 1'b1};

   // Character codes
   localparam logic [CH_WIDTH-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_WIDTH-1:0] CH_NINE  = 8'h39;
   localparam logic [CH_WIDTH-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CH_WIDTH-1:0] CH_STAR  = 8'h2A;
   localparam logic [CH_WIDTH-1:0] CH_SPACE = 8'h20;
   localparam logic [CH_WIDTH-1:0] CH_TAB   = 8'h09;
   localparam logic [CH_WIDTH-1:0] CH_CR    = 8'h0D;

   typedef enum logic [2:0] {
      PH_EXPECT_NUM = 3'd0,
      PH_IN_NUM     = 3'd1,
      PH_EXPECT_OP  = 3'd2,
      PH_DONE       = 3'd3,
      PH_ERROR      = 3'd4
   } phase_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK           = 2'd0,
      ST_UNKNOWN      = 2'd1,
      ST_NUM_EXPECTED = 2'd2
   } status_type;

   // Finished expression: the result is addend_a + addend_b
   typedef struct packed {
      status_type                status;
      logic [VALUE_WIDTH-1:0]    addend_a;
      logic [VALUE_WIDTH-1:0]    addend_b;
   } fin_type;

   function automatic logic is_digit(input logic [CH_WIDTH-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_blank(input logic [CH_WIDTH-1:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   // base * d for a single decimal digit, as four shifted partial products
   function automatic logic [VALUE_WIDTH-1:0] mul_digit(
      input logic [VALUE_WIDTH-1:0] base,
      input logic [DIGIT_WIDTH-1:0] d
   );
      logic [VALUE_WIDTH-1:0] acc;
      acc = VALUE_ZERO;
      for (int i = 0; i < DIGIT_WIDTH; i++) begin
         if (d[i]) begin
            acc = acc + (base << i);
         end
      end
      return acc;
   endfunction

endpackage

// ----- hw/rtl/ssee_step.sv -----
// Input register and parser state for the evaluator; one byte per cycle unless stalled by ssee_out.
// Depends on ssee_pkg. Hands finished expressions to ssee_out.
module ssee_step (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [ssee_pkg::CH_WIDTH-1:0] in_ch,
   input  logic                          in_last,
   output logic                          fin_valid,
   input  logic                          fin_ready,
   output ssee_pkg::fin_type             fin
);
   import ssee_pkg::*;

   logic                   in_valid_ff, in_valid_in;
   logic [CH_WIDTH-1:0]    in_ch_ff;
   logic                   in_last_ff;
   logic                   in_fire;

   phase_type              phase_ff, phase_in, phase_upd;
   logic [VALUE_WIDTH-1:0] sum_ff, sum_in, sum_upd;
   // base: product of the closed numbers of the current term
   // term: base times the number being built
   logic [VALUE_WIDTH-1:0] base_ff, base_in, base_upd;
   logic [VALUE_WIDTH-1:0] term_ff, term_in, term_upd;
   status_type             err_ff, err_in, err_upd;

   logic                   fin_valid_ff, fin_valid_in;
   fin_type                fin_ff, fin_in;

   logic                   ch_digit, ch_blank, ch_plus, ch_star;
   logic [DIGIT_WIDTH-1:0] digit_val;
   logic [VALUE_WIDTH-1:0] closed, base_digit, term_grow;

   // Handshake on the input register
   assign in_fire     = in_valid_ff && (!fin_valid_ff || fin_ready);
   assign in_ready    = !in_valid_ff || in_fire;
   assign in_valid_in = in_ready ? in_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (in_ready && in_valid) begin
         in_ch_ff   <= in_ch;
         in_last_ff <= in_last;
      end
   end

   // Character classes and the number arithmetic
   assign ch_digit   = is_digit(in_ch_ff);
   assign ch_blank   = is_blank(in_ch_ff);
   assign ch_plus    = (in_ch_ff == CH_PLUS);
   assign ch_star    = (in_ch_ff == CH_STAR);
   assign digit_val  = in_ch_ff[DIGIT_WIDTH-1:0];
   assign closed     = (phase_ff == PH_IN_NUM) ? term_ff : base_ff;
   assign base_digit = mul_digit(base_ff, digit_val);
   // product * (n*10 + d) = term*10 + base*d
   assign term_grow  = (term_ff << 3) + (term_ff << 1) + base_digit;

   // Next phase
   always_comb begin
      phase_upd = phase_ff;
      unique case (phase_ff)
         PH_IN_NUM: begin
            priority if (ch_digit) begin
               phase_upd = PH_IN_NUM;
            end else if (ch_blank) begin
               phase_upd = PH_EXPECT_OP;
            end else if (ch_plus || ch_star) begin
               phase_upd = PH_EXPECT_NUM;
            end else begin
               phase_upd = PH_ERROR;
            end
         end
         PH_EXPECT_OP: begin
            priority if (ch_blank) begin
               phase_upd = PH_EXPECT_OP;
            end else if (ch_plus || ch_star) begin
               phase_upd = PH_EXPECT_NUM;
            end else if (ch_digit) begin
               phase_upd = PH_DONE;
            end else begin
               phase_upd = PH_ERROR;
            end
         end
         PH_DONE, PH_ERROR: begin
            phase_upd = phase_ff;
         end
         default: begin
            priority if (ch_blank) begin
               phase_upd = PH_EXPECT_NUM;
            end else if (ch_digit) begin
               phase_upd = PH_IN_NUM;
            end else begin
               phase_upd = PH_ERROR;
            end
         end
      endcase
   end

   // Datapath updates per phase
   always_comb begin
      sum_upd  = sum_ff;
      base_upd = base_ff;
      term_upd = term_ff;
      err_upd  = err_ff;
      unique case (phase_ff)
         PH_IN_NUM, PH_EXPECT_OP: begin
            priority if (ch_digit && (phase_ff == PH_IN_NUM)) begin
               term_upd = term_grow;
            end else if (ch_plus) begin
               sum_upd  = sum_ff + closed;
               base_upd = VALUE_ONE;
            end else if (ch_digit) begin
               // second number: the expression so far is final
               sum_upd  = sum_ff + closed;
            end else if (ch_blank || ch_star) begin
               base_upd = closed;
            end else begin
               err_upd  = ST_UNKNOWN;
            end
         end
         PH_DONE, PH_ERROR: begin
            sum_upd = sum_ff;
         end
         default: begin
            priority if (ch_digit) begin
               term_upd = base_digit;
            end else if (ch_plus || ch_star) begin
               err_upd  = ST_NUM_EXPECTED;
            end else if (!ch_blank) begin
               err_upd  = ST_UNKNOWN;
            end
         end
      endcase
   end

   // Finished expression operands, taken from the updated state
   always_comb begin
      fin_in.status   = ST_OK;
      fin_in.addend_a = VALUE_ZERO;
      fin_in.addend_b = VALUE_ZERO;
      unique case (phase_upd)
         PH_IN_NUM: begin
            fin_in.addend_a = sum_upd;
            fin_in.addend_b = term_upd;
         end
         PH_EXPECT_OP: begin
            fin_in.addend_a = sum_upd;
            fin_in.addend_b = base_upd;
         end
         PH_DONE: begin
            fin_in.addend_a = sum_upd;
         end
         PH_ERROR: begin
            fin_in.status = err_upd;
         end
         default: begin
            fin_in.status = ST_NUM_EXPECTED;
         end
      endcase
   end

   // State advance; the last byte returns everything to the reset state
   always_comb begin
      phase_in = phase_ff;
      sum_in   = sum_ff;
      base_in  = base_ff;
      term_in  = term_ff;
      err_in   = err_ff;
      priority if (in_fire && in_last_ff) begin
         phase_in = PH_EXPECT_NUM;
         sum_in   = VALUE_ZERO;
         base_in  = VALUE_ONE;
         term_in  = VALUE_ZERO;
         err_in   = ST_OK;
      end else if (in_fire) begin
         phase_in = phase_upd;
         sum_in   = sum_upd;
         base_in  = base_upd;
         term_in  = term_upd;
         err_in   = err_upd;
      end
   end

   assign fin_valid_in = (in_fire && in_last_ff) || (fin_valid_ff && !fin_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_EXPECT_NUM;
         sum_ff       <= VALUE_ZERO;
         base_ff      <= VALUE_ONE;
         term_ff      <= VALUE_ZERO;
         err_ff       <= ST_OK;
         fin_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         sum_ff       <= sum_in;
         base_ff      <= base_in;
         term_ff      <= term_in;
         err_ff       <= err_in;
         fin_valid_ff <= fin_valid_in;
      end
      if (in_fire && in_last_ff) begin
         fin_ff <= fin_in;
      end
   end

   assign fin_valid = fin_valid_ff;
   assign fin       = fin_ff;

endmodule

// ----- hw/rtl/ssee_out.sv -----
// Result stage: final add of the finished expression and the output register.
// Depends on ssee_pkg; fed by ssee_step.
module ssee_out (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              fin_valid,
   output logic                              fin_ready,
   input  ssee_pkg::fin_type                 fin,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ssee_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [ssee_pkg::STATUS_WIDTH-1:0] rsp_tuser
);
   import ssee_pkg::*;

   logic                   out_valid_ff, out_valid_in;
   logic [VALUE_WIDTH-1:0] out_value_ff, out_value_in;
   status_type             out_status_ff;
   logic                   load;

   assign fin_ready    = !out_valid_ff || rsp_tready;
   assign load         = fin_valid && fin_ready;
   assign out_valid_in = load || (out_valid_ff && !rsp_tready);
   assign out_value_in = fin.addend_a + fin.addend_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (load) begin
         out_value_ff  <= out_value_in;
         out_status_ff <= fin.status;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_value_ff);
   assign rsp_tuser  = out_status_ff;

endmodule

// ----- hw/rtl/sum_of_products_expression_evaluator_top.sv -----
// Top level of the sum-of-products expression evaluator.
// Depends on ssee_pkg, ssee_step and ssee_out.
//
// Usage:
//   The req channel carries the expression text, one ASCII byte per item;
//   req_tlast marks the final byte. Numbers are decimal, joined by '+' and
//   '*' ('*' binds tighter); whitespace between tokens is skipped.
//   The rsp channel carries exactly one item per expression, produced by the
//   byte with req_tlast set: rsp_tdata holds the value (unsigned,
//   wrapped at VALUE_WIDTH bits, zero on error), rsp_tuser the status
//   (0 ok, 1 unknown character, 2 number expected).
//   Throughput: one byte per cycle while no result is blocked. Each byte costs one add tree
//   (number*10 plus product*digit) in the parser stage; no full multiplier.
//   The result of the last accepted byte passes through the input register,
//   the parser/finish register, the adder and the output register.
//   Reset clears the parser to the start of a new expression and empties the
//   input, finish and output registers. After each result the parser restarts
//   on its own. When rsp_tready is low the result holds in the output register;
//   a later result waits in the finish register. While that result is blocked the
//   parser holds, the input register takes one more byte and req_tready drops.
module sum_of_products_expression_evaluator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ssee_pkg::CH_WIDTH-1:0]     req_tdata,  // [7:0] ch
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ssee_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // [VALUE_WIDTH-1:0] value
   output logic [ssee_pkg::STATUS_WIDTH-1:0] rsp_tuser   // [1:0] status
);
   import ssee_pkg::*;

   logic    fin_valid;
   logic    fin_ready;
   fin_type fin;

   // Parser: input register plus running sum / term state
   ssee_step u_step (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_ch     (req_tdata),
      .in_last   (req_tlast),
      .fin_valid (fin_valid),
      .fin_ready (fin_ready),
      .fin       (fin)
   );

   // Final add and output register
   ssee_out u_out (
      .clock      (clock),
      .reset      (reset),
      .fin_valid  (fin_valid),
      .fin_ready  (fin_ready),
      .fin        (fin),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
